>>> rtl/fsitd_pkg.sv
// shared constants and the power-of-ten multiple table for the decimal formatter
package fsitd_pkg;

   localparam logic [7:0] PCT_CHAR   = 8'd37;
   localparam logic [7:0] MINUS_CHAR = 8'd45;
   localparam logic [7:0] ZERO_CHAR  = 8'd48;

   localparam int NUM_DIGITS  = 10;
   localparam int TAB_WIDTH   = 34;
   localparam int ARG_WIDTH   = 32;
   localparam int CHAR_WIDTH  = 8;

   // digit multiples d * 10^p for p = 0..9, d = 1..9 (9e9 needs 34 bits)
   typedef logic [NUM_DIGITS-1:0][9:1][TAB_WIDTH-1:0] mult_tab_type;

   function automatic mult_tab_type build_mult_tab();
      mult_tab_type tab;
      logic [TAB_WIDTH-1:0] pw;
      pw = TAB_WIDTH'(1);
      for (int p = 0; p < NUM_DIGITS; p++) begin
         for (int d = 1; d < 10; d++) begin
            tab[p][d] = TAB_WIDTH'(pw * TAB_WIDTH'(d));
         end
         pw = TAB_WIDTH'(pw * TAB_WIDTH'(10));
      end
      return tab;
   endfunction

   localparam mult_tab_type MULT_TAB = build_mult_tab();

endpackage

>>> rtl/format_stream_int_to_decimal.sv
// format-byte stream to ascii bytes, '%' prints the 32-bit signed argument in decimal
//
// usage:
//   req channel: one transfer per format byte, req_tdata = {arg_value, format_char}
//   rsp channel: one transfer per output byte, rsp_tlast marks the last byte of
//     the run caused by one request
//   a byte other than '%' comes back as itself with tlast set; a '%' yields an
//     optional '-' followed by the decimal digits, most significant first, no
//     leading zeros
// path: the bytes of a request pass the input register, magnitude register, digit
//   engine and output register
// output: a plain byte yields one byte, a '%' one byte per digit plus one for a minus
//   (up to 11); the digit engine emits one byte per cycle while the output register is
//   free, and meanwhile the input and magnitude registers hold the next two requests
// reset: synchronous, active high; clears all valid flags, no bytes are pending
// stall: when rsp_tready is low the output register holds its byte, the engine
//   and the stages before it fill up and req_tready drops only once all are full
module format_stream_int_to_decimal (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] format_char, [39:8] arg_value (signed)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tlast    // last byte of the run
);
   import fsitd_pkg::*;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [CHAR_WIDTH-1:0] in_char_ff, in_char_in;
   logic [ARG_WIDTH-1:0]  in_arg_ff, in_arg_in;

   // magnitude register
   logic                  prep_valid_ff, prep_valid_in;
   logic [CHAR_WIDTH-1:0] prep_char_ff, prep_char_in;
   logic                  prep_pct_ff, prep_pct_in;
   logic                  prep_neg_ff, prep_neg_in;
   logic [ARG_WIDTH-1:0]  prep_mag_ff, prep_mag_in;

   // digit engine
   logic                  eng_valid_ff, eng_valid_in;
   logic [CHAR_WIDTH-1:0] eng_char_ff, eng_char_in;
   logic                  eng_pct_ff, eng_pct_in;
   logic                  eng_minus_ff, eng_minus_in;
   logic [ARG_WIDTH-1:0]  eng_rem_ff, eng_rem_in;
   logic [3:0]            eng_pos_ff, eng_pos_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0] rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   // handshake between stages
   logic out_free, eng_fire, eng_final, eng_load, prep_load, req_fire;

   // engine datapath
   logic [CHAR_WIDTH-1:0] emit_char;
   logic [3:0]            digit, top_pos;
   logic [TAB_WIDTH-1:0]  rem_ext, sub_val, prep_mag_ext;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign eng_fire  = eng_valid_ff && out_free;
   // final byte: echoed char, or the units digit
   assign eng_final = !eng_pct_ff || (!eng_minus_ff && (eng_pos_ff == 4'd0));
   assign eng_load  = prep_valid_ff && (!eng_valid_ff || (eng_fire && eng_final));
   assign prep_load = in_valid_ff && (!prep_valid_ff || eng_load);
   assign req_tready = !in_valid_ff || prep_load;
   assign req_fire   = req_tvalid && req_tready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_arg_in   = in_arg_ff;
      if (prep_load) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata[7:0];
         in_arg_in   = req_tdata[39:8];
      end
   end

   // magnitude as unsigned, so the most negative value does not overflow
   always_comb begin
      prep_valid_in = prep_valid_ff;
      prep_char_in  = prep_char_ff;
      prep_pct_in   = prep_pct_ff;
      prep_neg_in   = prep_neg_ff;
      prep_mag_in   = prep_mag_ff;
      if (eng_load) begin
         prep_valid_in = 1'b0;
      end
      if (prep_load) begin
         prep_valid_in = 1'b1;
         prep_char_in  = in_char_ff;
         prep_pct_in   = (in_char_ff == PCT_CHAR);
         prep_neg_in   = in_arg_ff[ARG_WIDTH-1];
         prep_mag_in   = in_arg_ff[ARG_WIDTH-1] ? (ARG_WIDTH'(0) - in_arg_ff) : in_arg_ff;
      end
   end

   // index of the leading digit: how many powers 10^1..10^9 fit in the magnitude
   assign prep_mag_ext = {2'b00, prep_mag_ff};
   always_comb begin
      top_pos = 4'd0;
      for (int k = 1; k < NUM_DIGITS; k++) begin
         top_pos = top_pos + 4'(prep_mag_ext >= MULT_TAB[k][1]);
      end
   end

   // current digit: how many multiples of 10^pos fit in the remainder
   assign rem_ext = {2'b00, eng_rem_ff};
   always_comb begin
      digit = 4'd0;
      for (int d = 1; d < 10; d++) begin
         digit = digit + 4'(rem_ext >= MULT_TAB[eng_pos_ff][d]);
      end
   end
   assign sub_val = (digit == 4'd0) ? TAB_WIDTH'(0) : MULT_TAB[eng_pos_ff][digit];

   always_comb begin
      if (!eng_pct_ff) begin
         emit_char = eng_char_ff;
      end else if (eng_minus_ff) begin
         emit_char = MINUS_CHAR;
      end else begin
         emit_char = ZERO_CHAR + CHAR_WIDTH'(digit);
      end
   end

   // engine: one byte per fire, minus first, then digits down to position zero
   always_comb begin
      eng_valid_in = eng_valid_ff;
      eng_char_in  = eng_char_ff;
      eng_pct_in   = eng_pct_ff;
      eng_minus_in = eng_minus_ff;
      eng_rem_in   = eng_rem_ff;
      eng_pos_in   = eng_pos_ff;
      if (eng_fire) begin
         if (eng_final) begin
            eng_valid_in = 1'b0;
         end else if (eng_minus_ff) begin
            eng_minus_in = 1'b0;
         end else begin
            eng_rem_in = ARG_WIDTH'(rem_ext - sub_val);
            eng_pos_in = eng_pos_ff - 4'd1;
         end
      end
      if (eng_load) begin
         eng_valid_in = 1'b1;
         eng_char_in  = prep_char_ff;
         eng_pct_in   = prep_pct_ff;
         eng_minus_in = prep_pct_ff && prep_neg_ff;
         eng_rem_in   = prep_mag_ff;
         eng_pos_in   = top_pos;
      end
   end

   // output register, parts the engine from the receiver
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = eng_valid_ff;
         rsp_char_in  = emit_char;
         rsp_last_in  = eng_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prep_valid_ff <= 1'b0;
         eng_valid_ff  <= 1'b0;
         eng_minus_ff  <= 1'b0;
         eng_pos_ff    <= 4'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         prep_valid_ff <= prep_valid_in;
         eng_valid_ff  <= eng_valid_in;
         eng_minus_ff  <= eng_minus_in;
         eng_pos_ff    <= eng_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff   <= in_char_in;
      in_arg_ff    <= in_arg_in;
      prep_char_ff <= prep_char_in;
      prep_pct_ff  <= prep_pct_in;
      prep_neg_ff  <= prep_neg_in;
      prep_mag_ff  <= prep_mag_in;
      eng_char_ff  <= eng_char_in;
      eng_pct_ff   <= eng_pct_in;
      eng_rem_ff   <= eng_rem_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // digit position never leaves the ten-digit range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      eng_valid_ff |-> (eng_pos_ff < 4'(NUM_DIGITS)))
      else $error("digit position out of range");

   // a pending minus only belongs to a '%' request
   a_minus_pct: assert property (@(posedge clock) disable iff (reset)
      (eng_valid_ff && eng_minus_ff) |-> eng_pct_ff)
      else $error("minus pending on an echoed byte");

   // a digit byte is always a decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (eng_valid_ff && eng_pct_ff && !eng_minus_ff) |-> (digit <= 4'd9))
      else $error("digit above nine");

   // once a non-final byte is taken the run continues without a gap
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tready && !rsp_last_ff) |=> rsp_valid_ff)
      else $error("gap inside an output run");
`endif

endmodule
